@@ hdl/cfe_pkg.sv @@
// Package: shared types, codes and sizes of the constant folding engine.
package cfe_pkg;

    localparam int MAX_VALUES = 1024;
    localparam int ID_W       = $clog2(MAX_VALUES);
    localparam int CNT_W      = 11;
    localparam int EPOCH_W    = 8;

    // Instruction codes
    localparam logic [4:0] F_CONST  = 5'd0;
    localparam logic [4:0] F_ADD    = 5'd1;
    localparam logic [4:0] F_SUB    = 5'd2;
    localparam logic [4:0] F_MUL    = 5'd3;
    localparam logic [4:0] F_DIV    = 5'd4;
    localparam logic [4:0] F_MOD    = 5'd5;
    localparam logic [4:0] F_SHL    = 5'd6;
    localparam logic [4:0] F_SHR    = 5'd7;
    localparam logic [4:0] F_AND    = 5'd8;
    localparam logic [4:0] F_OR     = 5'd9;
    localparam logic [4:0] F_XOR    = 5'd10;
    localparam logic [4:0] F_EQ     = 5'd11;
    localparam logic [4:0] F_NE     = 5'd12;
    localparam logic [4:0] F_LT     = 5'd13;
    localparam logic [4:0] F_GT     = 5'd14;
    localparam logic [4:0] F_LE     = 5'd15;
    localparam logic [4:0] F_GE     = 5'd16;
    localparam logic [4:0] F_LOGAND = 5'd17;
    localparam logic [4:0] F_LOGOR  = 5'd18;
    localparam logic [4:0] F_CLEAR  = 5'd19;

    typedef enum logic [1:0] {
        K_CONST = 2'd0,
        K_BIN   = 2'd1,
        K_CLEAR = 2'd2,
        K_NOP   = 2'd3
    } t_kind;

    // Classified instruction as held in the queue
    typedef struct packed {
        t_kind       kind;
        logic [4:0]  func;
        logic        start_req;
        logic        dest_valid;
        logic [9:0]  dest_id;
        logic [9:0]  src_a;
        logic [9:0]  src_b;
        logic [31:0] immediate;
    } t_entry;

    // One table entry: mark, epoch of the mark, value
    typedef struct packed {
        logic               mark;
        logic [EPOCH_W-1:0] epoch;
        logic [31:0]        value;
    } t_tab;

    // Queue head toward the back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

endpackage

@@ hdl/cfe_if.sv @@
// Interfaces: instruction, result and configuration channels.
interface cfe_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  func;
    logic        start_req;
    logic        dest_valid;
    logic [9:0]  dest_id;
    logic [9:0]  src_a;
    logic [9:0]  src_b;
    logic [31:0] immediate;
    modport source (output valid, func, start_req, dest_valid, dest_id, src_a, src_b,
                    immediate, input ready);
    modport sink (input valid, func, start_req, dest_valid, dest_id, src_a, src_b,
                  immediate, output ready);
endinterface

interface cfe_out_if;
    logic        valid;
    logic        ready;
    logic        folded;
    logic [31:0] const_value;
    modport source (output valid, folded, const_value, input ready);
    modport sink (input valid, folded, const_value, output ready);
endinterface

interface cfe_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ hdl/cfe_ram.sv @@
// Generic simple dual-port RAM with registered read.
module cfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/cfe_front.sv @@
// Front end: accept instructions, classify them, hold them in a two-entry queue.
module cfe_front import cfe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cfe_in_if.sink i_in,
    input  logic  i_pop,
    output t_head o_head
);
    t_entry     r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    t_entry     w_ent;
    logic       w_push, w_pop;

    // Classify the incoming instruction
    always_comb begin
        w_ent.func       = i_in.func;
        w_ent.start_req  = i_in.start_req;
        w_ent.dest_valid = i_in.dest_valid;
        w_ent.dest_id    = i_in.dest_id;
        w_ent.src_a      = i_in.src_a;
        w_ent.src_b      = i_in.src_b;
        w_ent.immediate  = i_in.immediate;
        if (i_in.func == F_CONST) begin
            w_ent.kind = K_CONST;
        end else if (i_in.func <= F_LOGOR) begin
            w_ent.kind = K_BIN;
        end else if (i_in.func == F_CLEAR) begin
            w_ent.kind = K_CLEAR;
        end else begin
            w_ent.kind = K_NOP;
        end
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_cnt != 2'd0);

    // Store entry
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_ent;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.entry = r_q[r_rptr];
endmodule

@@ hdl/cfe_div.sv @@
// Iterative unsigned divider, one quotient bit per cycle.
module cfe_div import cfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] w_sh;

    // One restoring step
    always_comb begin
        w_sh = {r_rem[31:0], r_quo[31]};
        if (w_sh >= {1'b0, r_dvs}) begin
            n_rem = w_sh - {1'b0, r_dvs};
            n_quo = {r_quo[30:0], 1'b1};
        end else begin
            n_rem = w_sh;
            n_quo = {r_quo[30:0], 1'b0};
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 33'd0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[31:0];
endmodule

@@ hdl/cfe_back.sv @@
// Back end: table lookup, folding, table update and result register.
module cfe_back import cfe_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_head          i_head,
    output logic           o_pop,
    input  logic [CNT_W-1:0] i_lim,
    cfe_out_if.source      o_out
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_EXEC = 5'b00100,
        S_DIV  = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    t_state             r_state;
    logic               r_clr, r_clr_item;
    logic [ID_W-1:0]    r_clr_cnt;
    logic [EPOCH_W-1:0] r_epoch;
    t_entry             r_item;
    logic [31:0]        r_val;
    logic               r_fold, r_wr_en, r_wr_mark;
    logic               r_neg_q, r_neg_r, r_is_mod;
    logic               r_out_valid, r_out_fold;
    logic [31:0]        r_out_val;

    t_tab            w_rd_a, w_rd_b, w_wdata;
    logic            w_we;
    logic [ID_W-1:0] w_waddr;
    logic            w_ka, w_kb, w_dest_ok, w_out_free;
    logic [31:0]     w_a, w_b, w_cval, w_ma, w_mb;
    logic            w_div_start, w_div_done;
    logic [31:0]     w_quo, w_rem;

    // Table, duplicated for two read ports
    cfe_ram #(.WIDTH($bits(t_tab)), .DEPTH(MAX_VALUES)) u_ram_a (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_item.src_a[ID_W-1:0]), .o_rdata(w_rd_a)
    );
    cfe_ram #(.WIDTH($bits(t_tab)), .DEPTH(MAX_VALUES)) u_ram_b (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_item.src_b[ID_W-1:0]), .o_rdata(w_rd_b)
    );

    cfe_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_dividend(w_ma), .i_divisor(w_mb), .o_done(w_div_done),
        .o_quo(w_quo), .o_rem(w_rem)
    );

    // Known checks on read data
    assign w_a       = w_rd_a.value;
    assign w_b       = w_rd_b.value;
    assign w_ka      = w_rd_a.mark && (w_rd_a.epoch == r_epoch)
                       && ({1'b0, r_item.src_a} < i_lim);
    assign w_kb      = w_rd_b.mark && (w_rd_b.epoch == r_epoch)
                       && ({1'b0, r_item.src_b} < i_lim);
    assign w_dest_ok = r_item.dest_valid && ({1'b0, r_item.dest_id} < i_lim);
    assign w_ma      = w_a[31] ? (32'd0 - w_a) : w_a;
    assign w_mb      = w_b[31] ? (32'd0 - w_b) : w_b;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_div_start = (r_state == S_EXEC) && !r_clr && (r_item.kind == K_BIN)
                         && w_ka && w_kb && (w_b != 32'd0)
                         && ((r_item.func == F_DIV) || (r_item.func == F_MOD));
    assign o_pop = (r_state == S_IDLE) && !r_clr && i_head.valid;

    // Binary operations
    always_comb begin
        case (r_item.func)
            F_ADD:    w_cval = w_a + w_b;
            F_SUB:    w_cval = w_a - w_b;
            F_MUL:    w_cval = w_a * w_b;
            F_SHL:    w_cval = w_a << w_b[4:0];
            F_SHR:    w_cval = $unsigned($signed(w_a) >>> w_b[4:0]);
            F_AND:    w_cval = w_a & w_b;
            F_OR:     w_cval = w_a | w_b;
            F_XOR:    w_cval = w_a ^ w_b;
            F_EQ:     w_cval = {31'd0, w_a == w_b};
            F_NE:     w_cval = {31'd0, w_a != w_b};
            F_LT:     w_cval = {31'd0, $signed(w_a) < $signed(w_b)};
            F_GT:     w_cval = {31'd0, $signed(w_a) > $signed(w_b)};
            F_LE:     w_cval = {31'd0, $signed(w_a) <= $signed(w_b)};
            F_GE:     w_cval = {31'd0, $signed(w_a) >= $signed(w_b)};
            F_LOGAND: w_cval = {31'd0, (w_a != 32'd0) && (w_b != 32'd0)};
            F_LOGOR:  w_cval = {31'd0, (w_a != 32'd0) || (w_b != 32'd0)};
            default:  w_cval = 32'd0;
        endcase
    end

    // Table write: clearing sweep or write-back
    always_comb begin
        w_wdata.mark  = r_wr_mark;
        w_wdata.epoch = r_epoch;
        w_wdata.value = r_val;
        w_waddr       = r_item.dest_id[ID_W-1:0];
        w_we          = 1'b0;
        if (r_clr) begin
            w_wdata.mark = 1'b0;
            w_waddr      = r_clr_cnt;
            w_we         = 1'b1;
        end else if ((r_state == S_WB) && w_out_free) begin
            w_we = r_wr_en;
            if (r_item.kind == K_CONST) begin
                w_wdata.value = r_item.immediate;
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr       <= 1'b1;
            r_clr_item  <= 1'b0;
            r_clr_cnt   <= '0;
            r_epoch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_clr) begin
                // Sweep all marks clear
                r_clr_cnt <= r_clr_cnt + ID_W'(1);
                if (r_clr_cnt == ID_W'(MAX_VALUES - 1)) begin
                    r_clr   <= 1'b0;
                    r_epoch <= '0;
                    if (r_clr_item) begin
                        r_state <= S_RD;
                    end
                end
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (i_head.valid) begin
                            r_item <= i_head.entry;
                            r_state <= S_RD;
                            if (i_head.entry.start_req) begin
                                if (r_epoch == {EPOCH_W{1'b1}}) begin
                                    r_clr      <= 1'b1;
                                    r_clr_item <= 1'b1;
                                    r_clr_cnt  <= '0;
                                    r_state    <= S_IDLE;
                                end else begin
                                    r_epoch <= r_epoch + EPOCH_W'(1);
                                end
                            end
                        end
                    end
                    S_RD: begin
                        r_clr_item <= 1'b0;
                        r_state    <= S_EXEC;
                    end
                    S_EXEC: begin
                        r_fold    <= 1'b0;
                        r_val     <= 32'd0;
                        r_wr_mark <= 1'b0;
                        r_wr_en   <= 1'b0;
                        r_state   <= S_WB;
                        case (r_item.kind)
                            K_CONST: begin
                                r_wr_mark <= 1'b1;
                                r_wr_en   <= w_dest_ok;
                            end
                            K_BIN: begin
                                r_wr_en <= w_dest_ok;
                                if (w_ka && w_kb) begin
                                    r_fold    <= 1'b1;
                                    r_wr_mark <= 1'b1;
                                    r_val     <= w_cval;
                                    if (w_div_start) begin
                                        r_is_mod <= (r_item.func == F_MOD);
                                        r_neg_r  <= w_a[31];
                                        r_neg_q  <= w_a[31] ^ w_b[31];
                                        r_state  <= S_DIV;
                                    end
                                end
                            end
                            K_CLEAR: begin
                                r_wr_en <= w_dest_ok;
                            end
                            default: begin
                                r_wr_en <= 1'b0;
                            end
                        endcase
                    end
                    S_DIV: begin
                        // Hold until the divider finishes, then fix signs
                        if (w_div_done) begin
                            if (r_is_mod) begin
                                r_val <= r_neg_r ? (32'd0 - w_rem) : w_rem;
                            end else begin
                                r_val <= r_neg_q ? (32'd0 - w_quo) : w_quo;
                            end
                            r_state <= S_WB;
                        end
                    end
                    S_WB: begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_fold  <= r_fold;
                            r_out_val   <= r_val;
                            r_state     <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.folded      = r_out_fold;
    assign o_out.const_value = r_out_val;
endmodule

@@ hdl/constant_folding_engine.sv @@
// Top level of the constant folding engine.
//
// Channels: i_in carries IR instructions (valid/ready), o_out carries one
// result per instruction (folded flag and constant value), i_cfg writes the
// value_count register (always ready, one transaction per write).
// Instructions enter a two-entry queue; the back end takes one at a time:
// S_IDLE pops it, S_RD reads the table, S_EXEC computes and S_WB writes
// back and loads the result register, with S_DIV between S_EXEC and S_WB
// for a divide or modulo of known operands and a nonzero divisor (the
// bit-serial divider).
// Start of program advances a mark epoch; every 256th start, and reset,
// runs a clearing pass over all 1024 table entries, during which no
// instruction is taken from the queue.
// When the receiver stalls, the result stays in the output register, one
// more item may finish up to write-back and the queue keeps accepting
// until it is full.
module constant_folding_engine import cfe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    cfe_in_if.sink  i_in,
    cfe_out_if.source o_out,
    cfe_cfg_if.sink i_cfg
);
    logic [CNT_W-1:0] r_value_count;
    logic [CNT_W-1:0] w_lim;
    t_head            w_head;
    logic             w_pop;

    // Configuration register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_count <= CNT_W'(MAX_VALUES);
        end else if (i_cfg.valid) begin
            r_value_count <= i_cfg.data;
        end
    end

    // Limit the id range to the table depth
    assign w_lim = (r_value_count > CNT_W'(MAX_VALUES)) ? CNT_W'(MAX_VALUES) : r_value_count;

    cfe_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_pop(w_pop), .o_head(w_head)
    );

    cfe_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_head(w_head), .o_pop(w_pop),
        .i_lim(w_lim), .o_out(o_out)
    );
endmodule
